@@ rtl/shell_operator_spacer_assert.svh @@
// ----------------------------------------------------------------------------
// shell_operator_spacer_assert.svh
// Assertion macros for the shell operator spacer. They sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHELL_OPERATOR_SPACER_ASSERT_SVH
`define SHELL_OPERATOR_SPACER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shell_operator_spacer: same-cycle check failed");

// Next-cycle implication.
`define SOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shell_operator_spacer: next-cycle check failed");

`else

`define SOS_ASSERT_IMP(lbl, ante, cons)
`define SOS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/sos_pkg.sv @@
// ----------------------------------------------------------------------------
// sos_pkg
// Types, character codes and the operator decision function shared by the
// shell operator spacer modules.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam logic [7:0] SOS_CH_PIPE  = 8'h7C;
  localparam logic [7:0] SOS_CH_LT    = 8'h3C;
  localparam logic [7:0] SOS_CH_GT    = 8'h3E;
  localparam logic [7:0] SOS_CH_AMP   = 8'h26;
  localparam logic [7:0] SOS_CH_SEMI  = 8'h3B;
  localparam logic [7:0] SOS_CH_LPAR  = 8'h28;
  localparam logic [7:0] SOS_CH_RPAR  = 8'h29;
  localparam logic [7:0] SOS_CH_SQ    = 8'h27;
  localparam logic [7:0] SOS_CH_DQ    = 8'h22;
  localparam logic [7:0] SOS_CH_ONE   = 8'h31;
  localparam logic [7:0] SOS_CH_TWO   = 8'h32;
  localparam logic [7:0] SOS_CH_SP    = 8'h20;
  localparam logic [7:0] SOS_CH_ZERO  = 8'h30;
  localparam logic [7:0] SOS_CH_NINE  = 8'h39;
  localparam logic [7:0] SOS_CH_NUL   = 8'h00;

  localparam int SOS_MAX_BYTES   = 6;   // longest expansion of one head
  localparam int SOS_QUEUE_DEPTH = 2;   // front-to-back queue entries

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } sos_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } sos_out_t;

  // Character class flags, worked out once in the front part.
  typedef struct packed {
    logic sq;   // single quote
    logic dq;   // double quote
    logic fd;   // '1' or '2'
    logic gt;   // '>'
    logic amp;  // '&'
    logic dig;  // '0'..'9'
    logic op;   // single-character operator
  } sos_class_t;

  typedef struct packed {
    logic [7:0] ch;
    sos_class_t cls;
  } sos_ent_t;

  typedef struct packed {
    sos_ent_t ent;
    logic     eol;
  } sos_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sos_qstat_t;

  typedef struct packed {
    logic [1:0] win_cnt;
    logic       in_sq;
    logic       in_dq;
    logic [2:0] pend_cnt;
  } sos_bstat_t;

  typedef struct packed {
    logic [SOS_MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                    len;
    logic [2:0]                    used;
    logic                          sq;
    logic                          dq;
  } sos_dec_t;

  function automatic sos_class_t sos_classify(logic [7:0] c);
    sos_class_t k;
    k.sq  = (c == SOS_CH_SQ);
    k.dq  = (c == SOS_CH_DQ);
    k.fd  = (c == SOS_CH_ONE) || (c == SOS_CH_TWO);
    k.gt  = (c == SOS_CH_GT);
    k.amp = (c == SOS_CH_AMP);
    k.dig = (c >= SOS_CH_ZERO) && (c <= SOS_CH_NINE);
    k.op  = (c == SOS_CH_PIPE) || (c == SOS_CH_LT) || (c == SOS_CH_GT) ||
            (c == SOS_CH_AMP) || (c == SOS_CH_SEMI) || (c == SOS_CH_LPAR) ||
            (c == SOS_CH_RPAR);
    return k;
  endfunction

  // Decide the head b0; absent positions are all-zero entries.
  function automatic sos_dec_t sos_decide(sos_ent_t b0, sos_ent_t b1, sos_ent_t b2,
                                          sos_ent_t b3, logic sq, logic dq);
    sos_dec_t d;
    d          = '0;
    d.sq       = sq;
    d.dq       = dq;
    d.bytes[0] = b0.ch;
    d.len      = 3'd1;
    d.used     = 3'd1;
    if (b0.cls.sq && !dq) begin
      d.sq = !sq;
    end else if (b0.cls.dq && !sq) begin
      d.dq = !dq;
    end else if (!sq && !dq) begin
      if (b0.cls.fd && b1.cls.gt && b2.cls.amp && b3.cls.dig) begin
        d.bytes[0] = SOS_CH_SP;
        d.bytes[1] = b0.ch;
        d.bytes[2] = b1.ch;
        d.bytes[3] = b2.ch;
        d.bytes[4] = b3.ch;
        d.bytes[5] = SOS_CH_SP;
        d.len      = 3'd6;
        d.used     = 3'd4;
      end else if ((b0.cls.fd && b1.cls.gt) || (b0.cls.amp && b1.cls.amp) ||
                   (b0.cls.gt && (b1.cls.gt || b1.cls.amp))) begin
        d.bytes[0] = SOS_CH_SP;
        d.bytes[1] = b0.ch;
        d.bytes[2] = b1.ch;
        d.bytes[3] = SOS_CH_SP;
        d.len      = 3'd4;
        d.used     = 3'd2;
      end else if (b0.cls.op) begin
        d.bytes[0] = SOS_CH_SP;
        d.bytes[1] = b0.ch;
        d.bytes[2] = SOS_CH_SP;
        d.len      = 3'd3;
      end
    end
    return d;
  endfunction

endpackage

@@ rtl/shell_operator_spacer.sv @@
// ----------------------------------------------------------------------------
// shell_operator_spacer
// Streams a command line one character per request and puts spaces around
// shell operators found outside quotes, then closes the line with a zero
// terminator.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                    Carries
//  in       in_valid/in_ready/in_data   one character, or the end-of-line request
//  out      out_valid/out_ready/out_data one output byte; last on the terminator
//
//  Rate: a sustained stream of ordinary characters runs at one request per
//  cycle while out_ready holds. A decided operator head drains 3, 4 or 6
//  bytes at one byte per cycle, while out_ready holds, through the single
//  output register, which is the throughput limit. End of line decides the
//  held heads one after another, each once the bytes of the one before have
//  drained, and then sends the terminator.
//  Reset: rst_n is synchronous and active low; it clears the window count,
//  quote state, queue and output valid. No clearing pass is needed.
//  Stalls: the front register, the two-entry queue and any free window slots
//  absorb a few requests while a result waits for out_ready; once they fill,
//  in_ready drops until the back part moves again.
// ----------------------------------------------------------------------------
`include "shell_operator_spacer_assert.svh"

module shell_operator_spacer import sos_pkg::*; #(
  parameter int QUEUE_DEPTH = SOS_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sos_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sos_out_t out_data
);

  // Front to queue.
  logic       q_push;
  sos_item_t  q_item;
  sos_qstat_t q_stat;

  // Queue to back.
  logic       q_valid;
  sos_item_t  q_head;
  logic       q_pop;

  sos_bstat_t b_stat;

  // Register and classify incoming requests; drop zero characters here.
  sos_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // Hold classified items until the back part is free to take them.
  sos_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head),
    .stat       (q_stat)
  );

  // Window, quote tracking, head decision and byte drain.
  sos_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (b_stat)
  );

  // The front never pushes into a full queue.
  `SOS_ASSERT_IMP(a_push_room, q_push, !q_stat.full)
  // Pending bytes never exceed the longest expansion.
  `SOS_ASSERT_IMP(a_pend_bound, 1'b1, b_stat.pend_cnt <= 3'(SOS_MAX_BYTES))
  // Taking the end request leaves an empty window and closed quotes.
  `SOS_ASSERT_NXT(a_eol_clear, q_pop && q_head.eol,
                  b_stat.win_cnt == 2'd0 && !b_stat.in_sq && !b_stat.in_dq)
  // Only the terminator carries last, and it is a zero byte.
  `SOS_ASSERT_IMP(a_term_zero, out_valid && out_data.last, out_data.char_out == SOS_CH_NUL)

endmodule

@@ rtl/sos_front.sv @@
// ----------------------------------------------------------------------------
// sos_front
// Input stage: registers each request, drops zero characters and attaches
// the character class flags before handing the item to the queue.
// ----------------------------------------------------------------------------
module sos_front import sos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sos_in_t   in_data,
  input  logic      q_full,
  output logic      q_push,
  output sos_item_t q_item
);

  logic      f_valid_r, f_valid_nxt;
  sos_item_t f_item_r, f_item_nxt;
  logic      in_fire;
  logic      keep;

  always_comb begin
    q_push   = f_valid_r && !q_full;
    in_ready = !f_valid_r || q_push;
    in_fire  = in_valid && in_ready;
    keep     = in_data.end_of_line || (in_data.char_in != SOS_CH_NUL);

    f_item_nxt.ent.ch  = in_data.char_in;
    f_item_nxt.ent.cls = sos_classify(in_data.char_in);
    f_item_nxt.eol     = in_data.end_of_line;

    if (in_fire && keep) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  assign q_item = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && keep) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

@@ rtl/sos_queue.sv @@
// ----------------------------------------------------------------------------
// sos_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module sos_queue import sos_pkg::*; #(
  parameter int DEPTH = SOS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sos_item_t  push_item,
  input  logic       pop,
  output logic       head_valid,
  output sos_item_t  head_item,
  output sos_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sos_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    stat.full  = (count_r == CNT_W'(DEPTH));
    stat.empty = (count_r == '0);
    head_valid = !stat.empty;
    head_item  = mem_r[rd_ptr_r];
    do_push    = push && !stat.full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = do_push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/sos_back.sv @@
// ----------------------------------------------------------------------------
// sos_back
// Execution part: holds the three-character window and quote state, decides
// the head character and drains the expanded bytes through the output
// register.
// ----------------------------------------------------------------------------
module sos_back import sos_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  sos_item_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output sos_out_t   out_data,
  output sos_bstat_t stat
);

  sos_ent_t   win_r [3];
  sos_ent_t   win_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       sq_r, sq_nxt;
  logic       dq_r, dq_nxt;
  sos_out_t   pend_r [SOS_MAX_BYTES];
  sos_out_t   pend_nxt [SOS_MAX_BYTES];
  logic [2:0] pend_cnt_r, pend_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  sos_out_t   out_data_r, out_data_nxt;

  logic       out_load_ok, drain, pend_free;
  logic       load, load_term;
  sos_ent_t   b [4];
  sos_dec_t   dec;
  logic [2:0] n_held;

  always_comb begin
    out_load_ok = !out_valid_r || out_ready;
    drain       = (pend_cnt_r != '0) && out_load_ok;
    pend_free   = (pend_cnt_r == '0) || ((pend_cnt_r == 3'd1) && out_load_ok);

    // Positions past the held count read as no character.
    for (int i = 0; i < 3; i++) begin
      b[i] = (cnt_r > 2'(i)) ? win_r[i] : '0;
    end
    b[3]   = q_head.eol ? '0 : q_head.ent;
    dec    = sos_decide(b[0], b[1], b[2], b[3], sq_r, dq_r);
    n_held = q_head.eol ? {1'b0, cnt_r} : 3'd4;

    for (int i = 0; i < 3; i++) begin
      win_nxt[i] = win_r[i];
    end
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    dq_nxt    = dq_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    load_term = 1'b0;

    if (q_valid) begin
      if (q_head.eol) begin
        if (pend_free) begin
          if (cnt_r != 2'd0) begin
            load = 1'b1;
          end else begin
            load_term = 1'b1;
            q_pop     = 1'b1;
          end
        end
      end else if (cnt_r != 2'd3) begin
        win_nxt[cnt_r] = q_head.ent;
        cnt_nxt        = cnt_r + 2'd1;
        q_pop          = 1'b1;
      end else if (pend_free) begin
        load  = 1'b1;
        q_pop = 1'b1;
      end
    end

    if (load) begin
      cnt_nxt = 2'(n_held - dec.used);
      sq_nxt  = dec.sq;
      dq_nxt  = dec.dq;
      case (dec.used)
        3'd1: begin
          win_nxt[0] = b[1];
          win_nxt[1] = b[2];
          win_nxt[2] = b[3];
        end
        3'd2: begin
          win_nxt[0] = b[2];
          win_nxt[1] = b[3];
        end
        default: begin
        end
      endcase
    end
    if (load_term) begin
      cnt_nxt = 2'd0;
      sq_nxt  = 1'b0;
      dq_nxt  = 1'b0;
    end

    // Advance the pending bytes, then refill when a decision lands.
    for (int i = 0; i < SOS_MAX_BYTES - 1; i++) begin
      pend_nxt[i] = drain ? pend_r[i + 1] : pend_r[i];
    end
    pend_nxt[SOS_MAX_BYTES-1] = pend_r[SOS_MAX_BYTES-1];
    pend_cnt_nxt = pend_cnt_r - 3'(drain);
    if (load) begin
      for (int i = 0; i < SOS_MAX_BYTES; i++) begin
        pend_nxt[i].char_out = dec.bytes[i];
        pend_nxt[i].last     = 1'b0;
      end
      pend_cnt_nxt = dec.len;
    end else if (load_term) begin
      pend_nxt[0].char_out = SOS_CH_NUL;
      pend_nxt[0].last     = 1'b1;
      pend_cnt_nxt         = 3'd1;
    end

    out_data_nxt = out_data_r;
    if (drain) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_r[0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.win_cnt  = cnt_r;
  assign stat.in_sq    = sq_r;
  assign stat.in_dq    = dq_r;
  assign stat.pend_cnt = pend_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      sq_r        <= 1'b0;
      dq_r        <= 1'b0;
      pend_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sq_r        <= sq_nxt;
      dq_r        <= dq_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      win_r[i] <= win_nxt[i];
    end
    for (int i = 0; i < SOS_MAX_BYTES; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

endmodule

@@ sim/shell_operator_spacer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_operator_spacer_tb
// Streams command lines into the operator spacer one character per request
// and compares every output byte with a software copy of the spacing rules:
// quote tracking, the three-character lookahead, redirections, operator
// pairs, single operators and the flush that closes each line.
// ----------------------------------------------------------------------------
module shell_operator_spacer_tb;
  import sos_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 180;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_CAP    = 100;

  // --------------------------------------------------------------------------
  // Expected-byte tracker: a line-spacing predictor plus the queue of bytes
  // it has promised, checked in order against the output channel.
  // --------------------------------------------------------------------------
  class spacing_tracker;
    logic [7:0]  held [4];
    int unsigned held_count;
    bit          single_q;
    bit          double_q;
    sos_out_t    expected_bytes [$];
    int unsigned mismatch_count;
    int unsigned byte_index;

    function new();
      clear_line();
      mismatch_count = 0;
      byte_index     = 0;
    endfunction

    function void clear_line();
      foreach (held[i]) held[i] = SOS_CH_NUL;
      held_count = 0;
      single_q   = 1'b0;
      double_q   = 1'b0;
    endfunction

    function void emit(logic [7:0] c, logic fin);
      sos_out_t o;
      o.char_out = c;
      o.last     = fin;
      expected_bytes.push_back(o);
    endfunction

    function bit shell_op(logic [7:0] c);
      case (c)
        SOS_CH_PIPE, SOS_CH_LT, SOS_CH_GT, SOS_CH_AMP,
        SOS_CH_SEMI, SOS_CH_LPAR, SOS_CH_RPAR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Decide the oldest held character; empty slots read as NUL and match
    // nothing. Returns how many characters the head swallowed.
    function int unsigned space_head();
      logic [7:0] c0, c1, c2, c3;
      bit         redir_fd;
      c0 = held[0];
      c1 = held[1];
      c2 = held[2];
      c3 = held[3];
      if (c0 == SOS_CH_SQ && !double_q) begin
        single_q = !single_q;
        emit(c0, 1'b0);
        return 1;
      end
      if (c0 == SOS_CH_DQ && !single_q) begin
        double_q = !double_q;
        emit(c0, 1'b0);
        return 1;
      end
      if (!single_q && !double_q) begin
        redir_fd = (c0 == SOS_CH_ONE) || (c0 == SOS_CH_TWO);
        if (redir_fd && c1 == SOS_CH_GT && c2 == SOS_CH_AMP &&
            c3 >= SOS_CH_ZERO && c3 <= SOS_CH_NINE) begin
          emit(SOS_CH_SP, 1'b0);
          emit(c0, 1'b0);
          emit(c1, 1'b0);
          emit(c2, 1'b0);
          emit(c3, 1'b0);
          emit(SOS_CH_SP, 1'b0);
          return 4;
        end
        if ((redir_fd && c1 == SOS_CH_GT) ||
            (c0 == SOS_CH_AMP && c1 == SOS_CH_AMP) ||
            (c0 == SOS_CH_GT && (c1 == SOS_CH_GT || c1 == SOS_CH_AMP))) begin
          emit(SOS_CH_SP, 1'b0);
          emit(c0, 1'b0);
          emit(c1, 1'b0);
          emit(SOS_CH_SP, 1'b0);
          return 2;
        end
        if (shell_op(c0)) begin
          emit(SOS_CH_SP, 1'b0);
          emit(c0, 1'b0);
          emit(SOS_CH_SP, 1'b0);
          return 1;
        end
      end
      emit(c0, 1'b0);
      return 1;
    endfunction

    function void drop_head(int unsigned taken);
      int unsigned n;
      n = (taken > held_count) ? held_count : taken;
      for (int i = 0; i < 4; i++)
        held[i] = (i + n < 4) ? held[i + n] : SOS_CH_NUL;
      held_count = held_count - n;
    endfunction

    function void take_request(sos_in_t r);
      if (r.end_of_line) begin
        while (held_count > 0) drop_head(space_head());
        emit(SOS_CH_NUL, 1'b1);
        clear_line();
      end else if (r.char_in != SOS_CH_NUL) begin
        held[held_count] = r.char_in;
        held_count++;
        if (held_count == 4) drop_head(space_head());
      end
    endfunction

    task flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("mismatch at output byte %0d: %s", byte_index, what);
    endtask

    task match_byte(sos_out_t got);
      sos_out_t want;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b", got.char_out, got.last));
      end else begin
        want = expected_bytes.pop_front();
        if (got.char_out !== want.char_out)
          flag_mismatch($sformatf("char_out %02h, wanted %02h", got.char_out, want.char_out));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
      end
      byte_index++;
    endtask

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup
  // --------------------------------------------------------------------------
  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sos_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sos_out_t out_data;

  shell_operator_spacer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  spacing_tracker spacing;
  logic [7:0]     line_bytes [$];
  int unsigned    items_sent;
  bit             steady;     // no idling on either side while set
  bit             hold_off;   // ask the receiver for one long stall
  bit             holding;    // receiver is inside that stall

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, plus one long hold-off on request.
  // Each pass makes at most one assignment per edge to out_ready.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    holding = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        // Hold off long enough for the queue to fill and in_ready to drop.
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding  = 1'b0;
        hold_off = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Check every byte that crosses the output channel. Values read here are
  // the ones the edge itself sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) spacing.match_byte(out_data);
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Valid is only dropped
  // before a gap or a pause, so it never toggles within one time step.
  task automatic send_request(input sos_in_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    spacing.take_request(r);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    sos_in_t r;
    r.char_in     = c;
    r.end_of_line = 1'b0;
    send_request(r);
  endtask

  // Close the line; the character field is don't-care, so fill it randomly.
  task automatic send_eol();
    sos_in_t r;
    r.char_in     = 8'($urandom_range(0, 255));
    r.end_of_line = 1'b1;
    send_request(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and wait until every promised byte has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (spacing.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 6))
      0: return SOS_CH_PIPE;
      1: return SOS_CH_LT;
      2: return SOS_CH_GT;
      3: return SOS_CH_AMP;
      4: return SOS_CH_SEMI;
      5: return SOS_CH_LPAR;
      default: return SOS_CH_RPAR;
    endcase
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 4))
      0, 1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(SOS_CH_ZERO, SOS_CH_NINE));
      3: return SOS_CH_SP;
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_fd();
    return $urandom_range(0, 1) ? SOS_CH_ONE : SOS_CH_TWO;
  endfunction

  // Build one command line out of shell-like fragments: redirections,
  // operator pairs, single operators, quoted strings, words, raw noise bytes and NULs.
  function automatic void compose_line();
    int unsigned parts;
    int unsigned span;
    logic [7:0]  quote;
    line_bytes.delete();
    parts = $urandom_range(0, 6);
    repeat (parts) begin
      case ($urandom_range(0, 9))
        0: begin
          line_bytes.push_back(pick_fd());
          line_bytes.push_back(SOS_CH_GT);
          line_bytes.push_back(SOS_CH_AMP);
          // Mostly a digit; sometimes break the redirection.
          line_bytes.push_back(($urandom_range(0, 3) == 0) ? pick_word_char()
                               : 8'($urandom_range(SOS_CH_ZERO, SOS_CH_NINE)));
        end
        1: begin
          line_bytes.push_back(pick_fd());
          line_bytes.push_back(SOS_CH_GT);
        end
        2: begin
          case ($urandom_range(0, 2))
            0: begin
              line_bytes.push_back(SOS_CH_AMP);
              line_bytes.push_back(SOS_CH_AMP);
            end
            1: begin
              line_bytes.push_back(SOS_CH_GT);
              line_bytes.push_back(SOS_CH_GT);
            end
            default: begin
              line_bytes.push_back(SOS_CH_GT);
              line_bytes.push_back(SOS_CH_AMP);
            end
          endcase
        end
        3, 4: line_bytes.push_back(pick_op());
        5: begin
          // Quoted text with operators inside; the closing quote is
          // sometimes left off so the line ends inside the quote.
          quote = $urandom_range(0, 1) ? SOS_CH_SQ : SOS_CH_DQ;
          line_bytes.push_back(quote);
          span = $urandom_range(0, 4);
          repeat (span) begin
            case ($urandom_range(0, 4))
              0, 1: line_bytes.push_back(pick_op());
              2: line_bytes.push_back((quote == SOS_CH_SQ) ? SOS_CH_DQ : SOS_CH_SQ);
              default: line_bytes.push_back(pick_word_char());
            endcase
          end
          if ($urandom_range(0, 3) != 0) line_bytes.push_back(quote);
        end
        6, 7: begin
          span = $urandom_range(1, 4);
          repeat (span) line_bytes.push_back(pick_word_char());
        end
        8: line_bytes.push_back(8'($urandom_range(0, 255)));
        default: line_bytes.push_back(SOS_CH_NUL);
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned line_count;
    spacing    = new();
    items_sent = 0;
    steady     = 1'b0;
    hold_off   = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines. First: fd-to-fd redirection, && and >>, a NUL to be
    // ignored mid-line, then the single-character operators |, <, ;, ( and ).
    send_text("2>&9&&>>");
    send_char(SOS_CH_NUL);
    send_text("|<;()");
    send_eol();
    // Quotes: a single quote inside double quotes does not toggle, '&' stays
    // unspaced inside quotes, and the line ends with a single quote open
    // around a high byte and a '>'.
    send_text("\"'&\"'");
    send_char(8'hFF);
    send_char(SOS_CH_GT);
    send_eol();
    // Non-digit after "1>&" falls back to "1>", then '&' alone, then ">&",
    // and a lone '>' decided during the flush.
    send_text("1>&a>&>");
    send_eol();
    // Empty line: terminator only.
    send_eol();

    // Pause until every byte of the directed part is back.
    wait_drained();

    // Back-pressure: stall the receiver for a long stretch and keep the
    // sender busy with operator-heavy text so the block fills up.
    steady   = 1'b1;
    hold_off = 1'b1;
    while (!holding) @(posedge clk);
    send_text("2>&1|x&&y>>z;(a)");
    send_eol();
    steady = 1'b0;

    // Random lines, with stretches of no idling and an occasional drain.
    line_count = 0;
    while (items_sent < RANDOM_ITEMS) begin
      line_count++;
      if (line_count % 11 == 0) wait_drained();
      steady = (line_count % 7 == 3) || (line_count % 7 == 4);
      compose_line();
      foreach (line_bytes[i]) send_char(line_bytes[i]);
      send_eol();
    end
    steady = 1'b0;

    // Drain, then keep watching for DRAIN_CYCLES so that any stray byte shows.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (spacing.mismatch_count == 0 && spacing.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
